### hw/rtl/cts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and fixed field widths of the count sorted topic table:
// command and status codes, controller states, cell operations and the
// link that runs between neighboring cells.
// ----------------------------------------------------------------------------
package cts_pkg;

   // fixed widths of the port fields
   localparam int CMD_W      = 3;
   localparam int TOPIC_W    = 12;
   localparam int COUNT_W    = 32;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 3;
   localparam int USED_OUT_W = 7;
   localparam int SUM_W      = 38;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INC   = 3'd0,
      CMD_DEC   = 3'd1,
      CMD_QUERY = 3'd2,
      CMD_ADD   = 3'd3,
      CMD_READ  = 3'd4,
      CMD_CLEAR = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_INDEX = 3'd3,
      STAT_SAT       = 3'd4,
      STAT_ZERO      = 3'd5
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_GATHER,
      FSM_LOCATE,
      FSM_COMMIT
   } fsm_type;

   // operation broadcast to every cell
   typedef enum logic [3:0] {
      CELL_NOP,
      CELL_SCAN_TOPIC,
      CELL_SCAN_INDEX,
      CELL_ADD,
      CELL_LOCATE_INC,
      CELL_LOCATE_DEC,
      CELL_LOCATE_LAST,
      CELL_COMMIT_MOVE,
      CELL_COMMIT_DROP
   } cell_op_type;

   // flags handed from one cell to the next
   typedef struct packed {
      logic seen;   // a cell further left already matched the topic
      logic cond;   // this cell's compare result for the current operation
   } link_type;

endpackage
`default_nettype wire

### hw/rtl/cts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_cell
// One table entry: topic and count, plus a selected flag (entry found by the
// scan) and a target flag (entry picked by the locate step). Talks to its
// left and right neighbors and feeds an or-chain that gathers flagged data.
// ----------------------------------------------------------------------------
module cts_cell #(
   parameter int TOPIC_BITS = 12,
   parameter int COUNT_BITS = 32
) (
   input  wire                         clock,
   input  wire                         reset,
   input  cts_pkg::cell_op_type        cell_op,
   input  wire                         slot_valid,
   input  wire                         index_hit,
   input  wire  [TOPIC_BITS-1:0]       key_topic,
   input  wire  [COUNT_BITS-1:0]       cmp_count,
   input  wire  [COUNT_BITS-1:0]       wr_count,
   input  wire  [TOPIC_BITS-1:0]       fill_topic,
   input  wire  [COUNT_BITS-1:0]       fill_count,
   input  cts_pkg::link_type           left_link,
   input  wire                         right_cond,
   input  wire  [TOPIC_BITS-1:0]       left_topic,
   input  wire  [COUNT_BITS-1:0]       left_count,
   input  wire  [TOPIC_BITS-1:0]       chain_topic_in,
   input  wire  [COUNT_BITS-1:0]       chain_count_in,
   output cts_pkg::link_type           link_out,
   output logic [TOPIC_BITS-1:0]       topic_out,
   output logic [COUNT_BITS-1:0]       count_out,
   output logic [TOPIC_BITS-1:0]       chain_topic_out,
   output logic [COUNT_BITS-1:0]       chain_count_out,
   output logic                        sel_flag,
   output logic                        tgt_flag
);
   import cts_pkg::*;

   logic [TOPIC_BITS-1:0] topic_ff, topic_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  sel_ff, sel_in;
   logic                  tgt_ff, tgt_in;
   logic                  hit;
   logic                  cond;
   logic                  drive;

   // compare against the broadcast key or count
   always_comb begin
      hit = slot_valid && (topic_ff == key_topic);
      case (cell_op)
         CELL_ADD,
         CELL_LOCATE_DEC:  cond = slot_valid && (count_ff >= cmp_count);
         CELL_LOCATE_INC:  cond = slot_valid && (count_ff <= cmp_count);
         CELL_LOCATE_LAST: cond = slot_valid;
         default:          cond = 1'b0;
      endcase
      link_out.seen = left_link.seen || ((cell_op == CELL_SCAN_TOPIC) && hit);
      link_out.cond = cond;
   end

   // flag and entry updates
   always_comb begin
      sel_in   = sel_ff;
      tgt_in   = tgt_ff;
      topic_in = topic_ff;
      count_in = count_ff;
      case (cell_op)
         CELL_SCAN_TOPIC: sel_in = hit && !left_link.seen;
         CELL_SCAN_INDEX: sel_in = index_hit && slot_valid;
         CELL_ADD: begin
            // entries below the new count move one place right
            if (!cond) begin
               if (left_link.cond) begin
                  topic_in = key_topic;
                  count_in = cmp_count;
               end else begin
                  topic_in = left_topic;
                  count_in = left_count;
               end
            end
         end
         CELL_LOCATE_INC:  tgt_in = cond && !left_link.cond;
         CELL_LOCATE_DEC,
         CELL_LOCATE_LAST: tgt_in = cond && !right_cond;
         CELL_COMMIT_MOVE: begin
            // target takes the touched topic, the old spot takes the target's
            if (tgt_ff) begin
               topic_in = key_topic;
               count_in = wr_count;
            end else if (sel_ff) begin
               topic_in = fill_topic;
            end
         end
         CELL_COMMIT_DROP: begin
            if (sel_ff) begin
               topic_in = fill_topic;
               count_in = fill_count;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
         tgt_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         tgt_ff <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      topic_ff <= topic_in;
      count_ff <= count_in;
   end

   // or-chain of the flagged entry's data
   always_comb begin
      drive = ((cell_op == CELL_COMMIT_MOVE) || (cell_op == CELL_COMMIT_DROP)) ?
              tgt_ff : sel_ff;
      chain_topic_out = chain_topic_in | (drive ? topic_ff : '0);
      chain_count_out = chain_count_in | (drive ? count_ff : '0);
   end

   assign topic_out = topic_ff;
   assign count_out = count_ff;
   assign sel_flag  = sel_ff;
   assign tgt_flag  = tgt_ff;

endmodule
`default_nettype wire

### hw/rtl/count_sorted_topic_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// count_sorted_topic_table
// Table of (topic, count) entries kept in descending count order, built as a
// row of entry cells under a small controller.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// while the controller walks its steps: scan alone (add, clear, unused codes),
// scan and gather (query, read, and any increment or decrement that misses or
// saturates) or scan, gather, locate and commit (increment and decrement that
// change the table). The result appears on the rsp_ ports for exactly one cycle
// with rsp_strobe high, in the cycle in which busy is low again, so a new
// command can be started in that same cycle. The receiver cannot stall the
// block. In these steps every cell compares in parallel, the first match and
// the tie-run edge are found through neighbor links along the row, and one
// flagged entry is gathered per step over an or-chain. No memory clearing is
// needed after reset.
// ----------------------------------------------------------------------------
module count_sorted_topic_table #(
   parameter int DEPTH      = 64,
   parameter int TOPIC_BITS = 12,
   parameter int COUNT_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [cts_pkg::CMD_W-1:0]           req_cmd,
   input  wire  [cts_pkg::TOPIC_W-1:0]         req_topic_id,
   input  wire  [cts_pkg::COUNT_W-1:0]         req_add_count,
   input  wire  [cts_pkg::INDEX_W-1:0]         req_entry_index,
   output logic                                rsp_strobe,
   output logic [cts_pkg::STATUS_W-1:0]        rsp_status,
   output logic [cts_pkg::TOPIC_W-1:0]         rsp_found_topic,
   output logic [cts_pkg::COUNT_W-1:0]         rsp_found_count,
   output logic [cts_pkg::USED_OUT_W-1:0]      rsp_entries_used,
   output logic [cts_pkg::SUM_W-1:0]           rsp_total_count
);
   import cts_pkg::*;

   localparam int USED_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // controller registers
   fsm_type               state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [TOPIC_BITS-1:0] key_ff;
   logic [COUNT_BITS-1:0] add_value_ff;
   logic                  add_zero_ff;
   logic                  add_sat_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic                  found_ff, found_in;
   logic [COUNT_BITS-1:0] rcount_ff, rcount_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   // result registers
   logic                  rsp_strobe_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [TOPIC_W-1:0]    rsp_topic_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  respond;
   status_type            status_out;
   logic [TOPIC_W-1:0]    topic_out;
   logic [COUNT_W-1:0]    count_out;

   // request decode
   logic [31:0]           req_topic_wide;
   logic [TOPIC_BITS-1:0] req_key;
   logic                  req_sat;
   logic [COUNT_BITS-1:0] req_value;

   // cell row wiring
   cell_op_type           cell_op;
   logic [COUNT_BITS-1:0] cmp_count;
   logic [COUNT_BITS-1:0] wr_count;
   link_type              links [DEPTH+1];
   logic [TOPIC_BITS-1:0] chain_topic [DEPTH+1];
   logic [COUNT_BITS-1:0] chain_count [DEPTH+1];
   logic [TOPIC_BITS-1:0] cell_topic [DEPTH];
   logic [COUNT_BITS-1:0] cell_count [DEPTH];
   logic [DEPTH-1:0]      sel_vec;
   logic [DEPTH-1:0]      tgt_vec;

   // gathered entry and derived flags
   logic [TOPIC_BITS-1:0] bus_topic;
   logic [COUNT_BITS-1:0] bus_count;
   logic [31:0]           key_wide;
   logic [31:0]           bus_topic_wide;
   logic                  table_full;
   logic                  idx_in_range;

   // request field decode, topic trimmed or widened to the stored width
   always_comb begin
      req_topic_wide = 32'(req_topic_id);
      req_key        = req_topic_wide[TOPIC_BITS-1:0];
      req_sat        = req_add_count > 32'(COUNT_MAX);
      req_value      = req_sat ? COUNT_MAX : req_add_count[COUNT_BITS-1:0];
   end

   assign bus_topic      = chain_topic[DEPTH];
   assign bus_count      = chain_count[DEPTH];
   assign key_wide       = 32'(key_ff);
   assign bus_topic_wide = 32'(bus_topic);
   assign table_full     = used_ff == USED_W'(DEPTH);
   assign idx_in_range   = 32'(idx_ff) < 32'(used_ff);

   // row of cells; cell 0 always sees an open slot on its left for an add
   assign links[0].seen  = 1'b0;
   assign links[0].cond  = (cell_op == CELL_ADD);
   assign chain_topic[0] = '0;
   assign chain_count[0] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                  right_cond;
      logic                  slot_valid;
      logic                  index_hit;
      logic [TOPIC_BITS-1:0] left_topic;
      logic [COUNT_BITS-1:0] left_count;

      assign slot_valid = used_ff > USED_W'(g);
      assign index_hit  = 32'(idx_ff) == g;

      if (g == DEPTH - 1) begin : g_last
         assign right_cond = 1'b0;
      end else begin : g_inner
         assign right_cond = links[g+2].cond;
      end

      if (g == 0) begin : g_head
         assign left_topic = key_ff;
         assign left_count = cmp_count;
      end else begin : g_body
         assign left_topic = cell_topic[g-1];
         assign left_count = cell_count[g-1];
      end

      cts_cell #(
         .TOPIC_BITS (TOPIC_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cell_op         (cell_op),
         .slot_valid      (slot_valid),
         .index_hit       (index_hit),
         .key_topic       (key_ff),
         .cmp_count       (cmp_count),
         .wr_count        (wr_count),
         .fill_topic      (bus_topic),
         .fill_count      (bus_count),
         .left_link       (links[g]),
         .right_cond      (right_cond),
         .left_topic      (left_topic),
         .left_count      (left_count),
         .chain_topic_in  (chain_topic[g]),
         .chain_count_in  (chain_count[g]),
         .link_out        (links[g+1]),
         .topic_out       (cell_topic[g]),
         .count_out       (cell_count[g]),
         .chain_topic_out (chain_topic[g+1]),
         .chain_count_out (chain_count[g+1]),
         .sel_flag        (sel_vec[g]),
         .tgt_flag        (tgt_vec[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if ((cmd_ff == CMD_INC) || (cmd_ff == CMD_DEC) ||
                (cmd_ff == CMD_QUERY) || (cmd_ff == CMD_READ)) begin
               state_in = FSM_GATHER;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_GATHER: begin
            if (((cmd_ff == CMD_INC) && found_ff && (bus_count != COUNT_MAX)) ||
                ((cmd_ff == CMD_DEC) && found_ff)) begin
               state_in = FSM_LOCATE;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_LOCATE: state_in = FSM_COMMIT;
         FSM_COMMIT: state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      cell_op    = CELL_NOP;
      cmp_count  = rcount_ff;
      wr_count   = rcount_ff;
      respond    = 1'b0;
      status_out = STAT_OK;
      topic_out  = '0;
      count_out  = '0;
      found_in   = found_ff;
      rcount_in  = rcount_ff;
      used_in    = used_ff;
      sum_in     = sum_ff;
      case (state_ff)
         FSM_SCAN: begin
            cmp_count = add_value_ff;
            case (cmd_ff)
               CMD_INC,
               CMD_DEC,
               CMD_QUERY: begin
                  cell_op  = CELL_SCAN_TOPIC;
                  found_in = links[DEPTH].seen;
               end
               CMD_READ: begin
                  cell_op  = CELL_SCAN_INDEX;
                  found_in = idx_in_range;
               end
               CMD_ADD: begin
                  respond   = 1'b1;
                  topic_out = key_wide[TOPIC_W-1:0];
                  if (add_zero_ff) begin
                     status_out = STAT_ZERO;
                  end else if (table_full) begin
                     status_out = STAT_FULL;
                  end else begin
                     cell_op    = CELL_ADD;
                     used_in    = used_ff + USED_W'(1);
                     sum_in     = sum_ff + SUM_W'(add_value_ff);
                     status_out = add_sat_ff ? STAT_SAT : STAT_OK;
                     count_out  = COUNT_W'(add_value_ff);
                  end
               end
               CMD_CLEAR: begin
                  respond = 1'b1;
                  used_in = '0;
                  sum_in  = '0;
               end
               default: respond = 1'b1;
            endcase
         end
         FSM_GATHER: begin
            rcount_in = bus_count;
            case (cmd_ff)
               CMD_READ: begin
                  respond = 1'b1;
                  if (found_ff) begin
                     topic_out = bus_topic_wide[TOPIC_W-1:0];
                     count_out = COUNT_W'(bus_count);
                  end else begin
                     status_out = STAT_BAD_INDEX;
                  end
               end
               CMD_QUERY: begin
                  respond   = 1'b1;
                  topic_out = key_wide[TOPIC_W-1:0];
                  if (found_ff) begin
                     count_out = COUNT_W'(bus_count);
                  end else begin
                     status_out = STAT_NOT_FOUND;
                  end
               end
               CMD_INC: begin
                  topic_out = key_wide[TOPIC_W-1:0];
                  if (!found_ff) begin
                     respond    = 1'b1;
                     status_out = STAT_NOT_FOUND;
                  end else if (bus_count == COUNT_MAX) begin
                     respond    = 1'b1;
                     status_out = STAT_SAT;
                     count_out  = COUNT_W'(COUNT_MAX);
                  end
               end
               CMD_DEC: begin
                  topic_out = key_wide[TOPIC_W-1:0];
                  if (!found_ff) begin
                     respond    = 1'b1;
                     status_out = STAT_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end
         FSM_LOCATE: begin
            // head of the tie run for increment, tail for decrement,
            // last entry when the count drops to zero
            if (cmd_ff == CMD_INC) begin
               cell_op = CELL_LOCATE_INC;
            end else if (rcount_ff > COUNT_BITS'(1)) begin
               cell_op = CELL_LOCATE_DEC;
            end else begin
               cell_op = CELL_LOCATE_LAST;
            end
         end
         FSM_COMMIT: begin
            respond   = 1'b1;
            topic_out = key_wide[TOPIC_W-1:0];
            if (cmd_ff == CMD_INC) begin
               cell_op   = CELL_COMMIT_MOVE;
               wr_count  = rcount_ff + COUNT_BITS'(1);
               count_out = COUNT_W'(wr_count);
               sum_in    = sum_ff + SUM_W'(1);
            end else if (rcount_ff > COUNT_BITS'(1)) begin
               cell_op   = CELL_COMMIT_MOVE;
               wr_count  = rcount_ff - COUNT_BITS'(1);
               count_out = COUNT_W'(wr_count);
               sum_in    = sum_ff - SUM_W'(1);
            end else begin
               cell_op = CELL_COMMIT_DROP;
               used_in = used_ff - USED_W'(1);
               sum_in  = sum_ff - SUM_W'(rcount_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         used_ff       <= '0;
         sum_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         sum_ff        <= sum_in;
         rsp_strobe_ff <= respond;
      end
   end

   // command beat capture and working values
   always_ff @(posedge clock) begin
      if ((state_ff == FSM_IDLE) && start) begin
         cmd_ff       <= req_cmd;
         key_ff       <= req_key;
         add_value_ff <= req_value;
         add_zero_ff  <= req_add_count == '0;
         add_sat_ff   <= req_sat;
         idx_ff       <= req_entry_index;
      end
      found_ff  <= found_in;
      rcount_ff <= rcount_in;
      if (respond) begin
         rsp_status_ff <= status_out;
         rsp_topic_ff  <= topic_out;
         rsp_count_ff  <= count_out;
      end
   end

   assign busy             = state_ff != FSM_IDLE;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_topic  = rsp_topic_ff;
   assign rsp_found_count  = rsp_count_ff;
   assign rsp_entries_used = USED_OUT_W'(used_ff);
   assign rsp_total_count  = sum_ff;

`ifndef SYNTHESIS
   // a result beat only follows work in progress
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) != FSM_IDLE))
      else $error("result beat without a command in progress");

   // the scan selects at most one entry
   a_single_select: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_GATHER) |-> $onehot0(sel_vec))
      else $error("more than one entry selected");

   // a sorted table always yields exactly one swap partner
   a_single_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_COMMIT) |-> $onehot(tgt_vec))
      else $error("swap target not unique");

   // fill level stays within the row
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(DEPTH))
      else $error("entry count beyond depth");
`endif

endmodule
`default_nettype wire
